/* rtl/core/qrs_pkg.sv */
// Shared types and constants for the quicksort record sorter.
// No dependencies; the top level refers to it by scoped names.
`timescale 1ns / 1ps

package qrs_pkg;

    localparam int PORT_KEY_W  = 32;
    localparam int PORT_NODE_W = 16;
    localparam int PORT_DATA_W = 64;

    localparam int DEF_CAPACITY  = 64;
    localparam int DEF_KEY_BITS  = 32;
    localparam int DEF_NODE_BITS = 16;

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_SORT_START,
        ST_POP,
        ST_POP_WAIT,
        ST_PIV_WAIT,
        ST_SW_RDA,
        ST_SW_RDB,
        ST_SW_WRA,
        ST_SW_WRB,
        ST_SCAN_INIT,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_SCAN_INC,
        ST_PART_DONE,
        ST_PUSH_L,
        ST_EMIT_RD,
        ST_EMIT_LD
    } t_state;

endpackage

/* rtl/core/quicksort_record_sorter.sv */
// Quicksort record sorter: batch store, in-place quicksort sequencer, descending output.
// Depends on qrs_pkg (state type, port widths, parameter defaults).
//
//  channel   dir  fields (low bit up)                        end of run
//  s_axis    in   tdata: score_key[31:0] node_a node_b       tlast = batch_end
//  m_axis    out  tdata: out_key[31:0] out_node_a out_node_b tlast = out_last, tuser = overflow
//
//  Loading takes one cycle per word. After the closing word the sequencer sorts the store
//  through one record memory port pair: a swap is two reads and two writes; a scanned
//  element is read and compared, plus swapped if it goes left out of place; a range is
//  pop, pivot, setup and push plus two swaps. Output loads a word only once the sink took
//  the one before; s_axis_tready is low from the closing word until the last output word
//  is in the output register. Synchronous active-low reset clears control state only.
`timescale 1ns / 1ps

module quicksort_record_sorter #(
    parameter int CAPACITY  = qrs_pkg::DEF_CAPACITY,
    parameter int KEY_BITS  = qrs_pkg::DEF_KEY_BITS,
    parameter int NODE_BITS = qrs_pkg::DEF_NODE_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [qrs_pkg::PORT_DATA_W-1:0] s_axis_tdata,  // score_key, node_a, node_b
    input  logic                            s_axis_tlast,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [qrs_pkg::PORT_DATA_W-1:0] m_axis_tdata,  // out_key, out_node_a, out_node_b
    output logic                            m_axis_tlast,
    output logic                            m_axis_tuser   // overflow
);

    localparam int PKW  = qrs_pkg::PORT_KEY_W;
    localparam int PNW  = qrs_pkg::PORT_NODE_W;
    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int RW   = KEY_BITS + 2 * NODE_BITS;
    localparam int KEXT = (KEY_BITS > PKW) ? KEY_BITS : PKW;
    localparam int NEXT = (NODE_BITS > PNW) ? NODE_BITS : PNW;

    qrs_pkg::t_state r_state, n_state, r_ret;

    logic [RW-1:0]       r_mem [CAPACITY];
    logic [2*AW-1:0]     r_stk [CAPACITY];
    logic [RW-1:0]       r_rd;
    logic [2*AW-1:0]     r_stk_rd;
    logic [RW-1:0]       r_tmp;
    logic [KEY_BITS-1:0] r_pivot;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       r_depth;
    logic                r_drop;
    logic [AW-1:0]       r_lo, r_hi, r_k, r_place, r_sa, r_sb, r_pos;
    logic [PKW-1:0]      r_out_key;
    logic [PNW-1:0]      r_out_a, r_out_b;
    logic                r_out_last, r_out_ovf, r_out_valid;

    logic                w_mem_we;
    logic [AW-1:0]       w_mem_wa, w_mem_ra;
    logic [RW-1:0]       w_mem_wd;
    logic                w_stk_we;
    logic [AW-1:0]       w_stk_ra;
    logic [2*AW-1:0]     w_stk_wd;

    logic                w_in_acc, w_full;
    logic [CW-1:0]       w_cnt_nx;
    logic [KEXT-1:0]     w_in_key_ext, w_out_key_ext;
    logic [NEXT-1:0]     w_in_a_ext, w_in_b_ext, w_out_a_ext, w_out_b_ext;
    logic [RW-1:0]       w_in_rec;
    logic [KEY_BITS-1:0] w_rd_key;
    logic                w_le_pivot, w_push_r, w_push_l, w_stk_room;

    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_full        = (r_count == CW'(CAPACITY));
    assign w_cnt_nx      = w_full ? r_count : r_count + CW'(1);
    assign w_in_key_ext  = KEXT'(s_axis_tdata[PKW-1:0]);
    assign w_in_a_ext    = NEXT'(s_axis_tdata[PKW +: PNW]);
    assign w_in_b_ext    = NEXT'(s_axis_tdata[PKW+PNW +: PNW]);
    assign w_in_rec      = {w_in_key_ext[KEY_BITS-1:0], w_in_a_ext[NODE_BITS-1:0],
                            w_in_b_ext[NODE_BITS-1:0]};
    assign w_rd_key      = r_rd[RW-1 -: KEY_BITS];
    assign w_out_key_ext = KEXT'(w_rd_key);
    assign w_out_a_ext   = NEXT'(r_rd[2*NODE_BITS-1 -: NODE_BITS]);
    assign w_out_b_ext   = NEXT'(r_rd[NODE_BITS-1:0]);
    assign w_le_pivot    = (w_rd_key <= r_pivot);
    assign w_stk_room    = (r_depth < CW'(CAPACITY));
    assign w_push_r      = ({1'b0, r_place} + (AW+1)'(1) < {1'b0, r_hi}) && w_stk_room;
    assign w_push_l      = ({1'b0, r_place} > {1'b0, r_lo} + (AW+1)'(1)) && w_stk_room;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            qrs_pkg::ST_LOAD: begin
                if (w_in_acc && s_axis_tlast) n_state = qrs_pkg::ST_SORT_START;
            end
            qrs_pkg::ST_SORT_START: begin
                n_state = (r_count < CW'(2)) ? qrs_pkg::ST_EMIT_RD : qrs_pkg::ST_POP;
            end
            qrs_pkg::ST_POP: begin
                n_state = (r_depth == '0) ? qrs_pkg::ST_EMIT_RD : qrs_pkg::ST_POP_WAIT;
            end
            qrs_pkg::ST_POP_WAIT: n_state = qrs_pkg::ST_PIV_WAIT;
            qrs_pkg::ST_PIV_WAIT: n_state = qrs_pkg::ST_SW_RDA;
            qrs_pkg::ST_SW_RDA:   n_state = qrs_pkg::ST_SW_RDB;
            qrs_pkg::ST_SW_RDB:   n_state = qrs_pkg::ST_SW_WRA;
            qrs_pkg::ST_SW_WRA:   n_state = qrs_pkg::ST_SW_WRB;
            qrs_pkg::ST_SW_WRB:   n_state = r_ret;
            qrs_pkg::ST_SCAN_INIT: n_state = qrs_pkg::ST_SCAN_RD;
            qrs_pkg::ST_SCAN_RD: begin
                n_state = (r_k != r_hi) ? qrs_pkg::ST_SCAN_CMP : qrs_pkg::ST_SW_RDA;
            end
            qrs_pkg::ST_SCAN_CMP: begin
                if (!w_le_pivot)          n_state = qrs_pkg::ST_SCAN_RD;
                else if (r_place == r_k)  n_state = qrs_pkg::ST_SCAN_INC;
                else                      n_state = qrs_pkg::ST_SW_RDA;
            end
            qrs_pkg::ST_SCAN_INC:  n_state = qrs_pkg::ST_SCAN_RD;
            qrs_pkg::ST_PART_DONE: n_state = qrs_pkg::ST_PUSH_L;
            qrs_pkg::ST_PUSH_L:    n_state = qrs_pkg::ST_POP;
            qrs_pkg::ST_EMIT_RD: begin
                if (!r_out_valid) n_state = qrs_pkg::ST_EMIT_LD;
            end
            qrs_pkg::ST_EMIT_LD: begin
                n_state = (r_pos == '0) ? qrs_pkg::ST_LOAD : qrs_pkg::ST_EMIT_RD;
            end
            default: n_state = qrs_pkg::ST_LOAD;
        endcase
    end

    // memory ports and handshake
    always_comb begin
        s_axis_tready = (r_state == qrs_pkg::ST_LOAD);
        w_mem_we = 1'b0;
        w_mem_wa = r_sa;
        w_mem_wd = r_rd;
        w_mem_ra = r_k;
        w_stk_we = 1'b0;
        w_stk_wd = {r_lo, r_hi};
        w_stk_ra = AW'(r_depth - CW'(1));
        case (r_state)
            qrs_pkg::ST_LOAD: begin
                w_mem_we = w_in_acc && !w_full;
                w_mem_wa = r_count[AW-1:0];
                w_mem_wd = w_in_rec;
            end
            qrs_pkg::ST_SORT_START: begin
                w_stk_we = (r_count >= CW'(2));
                w_stk_wd = {AW'(0), AW'(r_count - CW'(1))};
            end
            qrs_pkg::ST_POP_WAIT: w_mem_ra = r_stk_rd[2*AW-1 -: AW];
            qrs_pkg::ST_SW_RDA:   w_mem_ra = r_sa;
            qrs_pkg::ST_SW_RDB:   w_mem_ra = r_sb;
            qrs_pkg::ST_SW_WRA: begin
                w_mem_we = 1'b1;
                w_mem_wa = r_sa;
                w_mem_wd = r_rd;
            end
            qrs_pkg::ST_SW_WRB: begin
                w_mem_we = 1'b1;
                w_mem_wa = r_sb;
                w_mem_wd = r_tmp;
            end
            qrs_pkg::ST_SCAN_RD: w_mem_ra = r_k;
            qrs_pkg::ST_PART_DONE: begin
                w_stk_we = w_push_r;
                w_stk_wd = {AW'(r_place + AW'(1)), r_hi};
            end
            qrs_pkg::ST_PUSH_L: begin
                w_stk_we = w_push_l;
                w_stk_wd = {r_lo, AW'(r_place - AW'(1))};
            end
            qrs_pkg::ST_EMIT_RD: w_mem_ra = r_pos;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) r_mem[w_mem_wa] <= w_mem_wd;
        r_rd <= r_mem[w_mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (w_stk_we) r_stk[r_depth[AW-1:0]] <= w_stk_wd;
        r_stk_rd <= r_stk[w_stk_ra];
    end

    // sequencer datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= qrs_pkg::ST_LOAD;
            r_count     <= '0;
            r_drop      <= 1'b0;
            r_depth     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (m_axis_tvalid && m_axis_tready) r_out_valid <= 1'b0;
            case (r_state)
                qrs_pkg::ST_LOAD: begin
                    if (w_in_acc) begin
                        r_count <= w_cnt_nx;
                        if (w_full) r_drop <= 1'b1;
                        r_pos <= AW'(w_cnt_nx - CW'(1));
                    end
                end
                qrs_pkg::ST_SORT_START: begin
                    if (r_count >= CW'(2)) r_depth <= CW'(1);
                end
                qrs_pkg::ST_POP: begin
                    if (r_depth != '0) r_depth <= r_depth - CW'(1);
                end
                qrs_pkg::ST_POP_WAIT: begin
                    r_lo <= r_stk_rd[2*AW-1 -: AW];
                    r_hi <= r_stk_rd[AW-1:0];
                end
                qrs_pkg::ST_PIV_WAIT: begin
                    r_pivot <= w_rd_key;
                    r_sa    <= r_lo;
                    r_sb    <= r_hi;
                    r_ret   <= qrs_pkg::ST_SCAN_INIT;
                end
                qrs_pkg::ST_SW_RDB: r_tmp <= r_rd;
                qrs_pkg::ST_SCAN_INIT: begin
                    r_place <= r_lo;
                    r_k     <= r_lo;
                end
                qrs_pkg::ST_SCAN_RD: begin
                    if (r_k == r_hi) begin
                        r_sa  <= r_place;
                        r_sb  <= r_hi;
                        r_ret <= qrs_pkg::ST_PART_DONE;
                    end
                end
                qrs_pkg::ST_SCAN_CMP: begin
                    if (!w_le_pivot) begin
                        r_k <= r_k + AW'(1);
                    end else begin
                        r_sa  <= r_place;
                        r_sb  <= r_k;
                        r_ret <= qrs_pkg::ST_SCAN_INC;
                    end
                end
                qrs_pkg::ST_SCAN_INC: begin
                    r_place <= r_place + AW'(1);
                    r_k     <= r_k + AW'(1);
                end
                qrs_pkg::ST_PART_DONE: begin
                    if (w_push_r) r_depth <= r_depth + CW'(1);
                end
                qrs_pkg::ST_PUSH_L: begin
                    if (w_push_l) r_depth <= r_depth + CW'(1);
                end
                qrs_pkg::ST_EMIT_LD: begin
                    r_out_valid <= 1'b1;
                    r_out_key   <= w_out_key_ext[PKW-1:0];
                    r_out_a     <= w_out_a_ext[PNW-1:0];
                    r_out_b     <= w_out_b_ext[PNW-1:0];
                    r_out_last  <= (r_pos == '0);
                    r_out_ovf   <= r_drop;
                    if (r_pos == '0) begin
                        r_count <= '0;
                        r_drop  <= 1'b0;
                    end else begin
                        r_pos <= r_pos - AW'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_b, r_out_a, r_out_key};
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_ovf;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("record count beyond capacity");

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= CW'(CAPACITY))
        else $error("range stack depth beyond capacity");

    a_scan_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == qrs_pkg::ST_SCAN_RD) |-> (r_lo <= r_place) && (r_place <= r_k)
                                           && (r_k <= r_hi))
        else $error("partition indexes out of order");

    a_load_to_sort: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && s_axis_tlast) |=> (r_state == qrs_pkg::ST_SORT_START) && (r_count != '0))
        else $error("closing word did not start the sort");

endmodule

/* tb/sv/tb_quicksort_record_sorter.sv */
// Testbench for quicksort_record_sorter: record batches go in, and every sorted output word
// is checked against an in-bench quicksort (first-element pivot, Lomuto split) of each batch.
// Depends on qrs_pkg and the quicksort_record_sorter RTL; needs no files or arguments.
`timescale 1ns / 1ps

module tb_quicksort_record_sorter;

    localparam int CAP        = qrs_pkg::DEF_CAPACITY;
    localparam int KEY_W      = qrs_pkg::PORT_KEY_W;
    localparam int NODE_W     = qrs_pkg::PORT_NODE_W;
    localparam int DATA_W     = qrs_pkg::PORT_DATA_W;
    localparam int SINK_HOLD  = 1500;
    localparam int END_SETTLE = 200;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
    } record_t;

    typedef struct packed {
        record_t rec;
        logic    last;
        logic    overflow;
    } sorted_word_t;

    typedef enum {KEYS_WIDE, KEYS_TIED, KEYS_NARROW, KEYS_RISING, KEYS_FALLING} key_pattern_t;
    typedef enum {SINK_OPEN, SINK_RANDOM, SINK_SPARSE} sink_mode_t;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [DATA_W-1:0] s_axis_tdata  = '0;    // score_key[31:0], node_a[47:32], node_b[63:48]
    logic              s_axis_tlast  = 1'b0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [DATA_W-1:0] m_axis_tdata;          // out_key[31:0], out_node_a[47:32], out_node_b[63:48]
    logic              m_axis_tlast;
    logic              m_axis_tuser;          // overflow

    record_t      batch_store[CAP];
    int           batch_count      = 0;
    bit           batch_dropped    = 1'b0;
    sorted_word_t pending_sorted[$];

    int  err_count        = 0;
    int  records_accepted = 0;
    int  batches_closed   = 0;
    int  overflow_batches = 0;
    int  words_checked    = 0;

    int  burst_left = 0;
    bit  src_steady = 1'b0;

    sink_mode_t sink_mode      = SINK_OPEN;
    int         sink_mode_left = 0;
    int         sink_hold_left = 0;
    int         sink_phase     = 0;
    bit         sink_hold_ask  = 1'b0;

    quicksort_record_sorter DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    function automatic void swap_records(int a, int b);
        record_t t;
        t = batch_store[a];
        batch_store[a] = batch_store[b];
        batch_store[b] = t;
    endfunction

    // Store one accepted record; on the closing word sort the batch and queue it high to low.
    function automatic void predict_record(record_t r, bit closes);
        int range_lo[CAP];
        int range_hi[CAP];
        int depth, lo, hi, place;
        logic [KEY_W-1:0] pivot;
        sorted_word_t w;
        if (batch_count < CAP) begin
            batch_store[batch_count] = r;
            batch_count++;
        end else begin
            batch_dropped = 1'b1;
        end
        if (!closes)
            return;
        if (batch_count >= 2) begin
            range_lo[0] = 0;
            range_hi[0] = batch_count - 1;
            depth = 1;
            while (depth > 0) begin
                depth--;
                lo = range_lo[depth];
                hi = range_hi[depth];
                pivot = batch_store[lo].key;
                place = lo;
                swap_records(lo, hi);
                for (int k = lo; k < hi; k++) begin
                    if (batch_store[k].key <= pivot) begin
                        swap_records(place, k);
                        place++;
                    end
                end
                swap_records(place, hi);
                if (place + 1 < hi && depth < CAP) begin
                    range_lo[depth] = place + 1;
                    range_hi[depth] = hi;
                    depth++;
                end
                if (place - 1 > lo && depth < CAP) begin
                    range_lo[depth] = lo;
                    range_hi[depth] = place - 1;
                    depth++;
                end
            end
        end
        for (int k = 0; k < batch_count; k++) begin
            w.rec      = batch_store[batch_count - 1 - k];
            w.last     = (k == batch_count - 1);
            w.overflow = batch_dropped;
            pending_sorted.push_back(w);
        end
        batches_closed++;
        if (batch_dropped)
            overflow_batches++;
        batch_count   = 0;
        batch_dropped = 1'b0;
    endfunction

    task automatic send_record(input record_t r, input bit closes);
        int gap;
        if (!src_steady && burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        if (burst_left > 0)
            burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {r.node_b, r.node_a, r.key};
        s_axis_tlast  <= closes;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        predict_record(r, closes);
        records_accepted++;
    endtask

    task automatic send_batch(input int n, input key_pattern_t pat);
        record_t r;
        for (int k = 0; k < n; k++) begin
            case (pat)
                KEYS_TIED:    r.key = KEY_W'($urandom_range(0, 3)) << 30;
                KEYS_NARROW:  r.key = KEY_W'($urandom_range(0, 255));
                KEYS_RISING:  r.key = (KEY_W'(k) << 24) | KEY_W'($urandom_range(0, 255));
                KEYS_FALLING: r.key = ~((KEY_W'(k) << 24) | KEY_W'($urandom_range(0, 255)));
                default:      r.key = $urandom();
            endcase
            r.node_a = NODE_W'($urandom());
            r.node_b = NODE_W'($urandom());
            send_record(r, k == n - 1);
        end
    endtask

    // Hold the source idle until every queued sorted word has come out.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        do
            @(posedge i_clk);
        while (pending_sorted.size() != 0);
    endtask

    task automatic test_directed();
        logic [KEY_W-1:0] rising[6];
        rising = '{32'h0000_0000, 32'h0000_0001, 32'h7FFF_FFFF,
                   32'h8000_0000, 32'hFFFF_FFFE, 32'hFFFF_FFFF};
        send_record(record_t'{32'h0000_0000, 16'h0000, 16'h0000}, 1'b1);
        send_record(record_t'{32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF}, 1'b1);
        send_record(record_t'{32'd5, 16'h0001, 16'h0002}, 1'b0);
        send_record(record_t'{32'd5, 16'h0003, 16'h0004}, 1'b1);
        for (int k = 0; k < 6; k++)
            send_record(record_t'{rising[k], NODE_W'(k), ~NODE_W'(k)}, k == 5);
        for (int k = 0; k < 6; k++)
            send_record(record_t'{rising[5 - k], NODE_W'(16'h8000 | k), NODE_W'(k)}, k == 5);
        for (int k = 0; k < 8; k++)
            send_record(record_t'{32'h8000_0000, NODE_W'(k), NODE_W'(16'hA5A5 ^ k)}, k == 7);
    endtask

    task automatic test_capacity();
        send_batch(CAP, KEYS_TIED);
        send_batch(CAP + 3, KEYS_WIDE);
    endtask

    task automatic test_random();
        int sent;
        int n;
        int pick;
        key_pattern_t pat;
        sent = 0;
        while (sent < 100) begin
            pick = $urandom_range(0, 99);
            if (pick < 80)
                n = $urandom_range(1, 12);
            else if (pick < 95)
                n = $urandom_range(13, 40);
            else
                n = $urandom_range(41, CAP);
            pat = key_pattern_t'($urandom_range(0, 4));
            src_steady = ($urandom_range(0, 9) < 3);
            send_batch(n, pat);
            sent += n;
            if ($urandom_range(0, 9) == 0)
                wait_drained();
        end
        src_steady = 1'b0;
    endtask

    // Stall the sink long enough that the block backs up, then keep offering words into it.
    task automatic test_backpressure();
        wait_drained();
        sink_hold_ask = 1'b1;
        src_steady    = 1'b1;
        for (int b = 0; b < 3; b++)
            send_batch(10, KEYS_TIED);
        src_steady = 1'b0;
        wait_drained();
    endtask

    always @(posedge i_clk) begin
        if (sink_hold_ask) begin
            sink_hold_ask  = 1'b0;
            sink_hold_left = SINK_HOLD;
        end
        if (sink_hold_left > 0) begin
            sink_hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            if (sink_mode_left == 0) begin
                sink_mode      = sink_mode_t'($urandom_range(0, 2));
                sink_mode_left = $urandom_range(20, 120);
            end
            sink_mode_left--;
            sink_phase++;
            case (sink_mode)
                SINK_OPEN:   m_axis_tready <= 1'b1;
                SINK_RANDOM: m_axis_tready <= ($urandom_range(0, 1) == 1);
                default:     m_axis_tready <= (sink_phase % 4 == 0);
            endcase
        end
    end

    function automatic void flag_mismatch(string what, logic [KEY_W-1:0] want,
                                          logic [KEY_W-1:0] got);
        err_count++;
        $display("%0t ns: %s mismatch: expected %h, actual %h", $time, what, want, got);
    endfunction

    always @(posedge i_clk) begin : check_sorted_word
        sorted_word_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            words_checked++;
            if (pending_sorted.size() == 0) begin
                err_count++;
                $display("%0t ns: word with none expected: expected none, actual %h/%b/%b",
                         $time, m_axis_tdata, m_axis_tlast, m_axis_tuser);
            end else begin
                want = pending_sorted.pop_front();
                if (m_axis_tdata[31:0] !== want.rec.key)
                    flag_mismatch("out_key", want.rec.key, m_axis_tdata[31:0]);
                if (m_axis_tdata[47:32] !== want.rec.node_a)
                    flag_mismatch("out_node_a", KEY_W'(want.rec.node_a),
                                  KEY_W'(m_axis_tdata[47:32]));
                if (m_axis_tdata[63:48] !== want.rec.node_b)
                    flag_mismatch("out_node_b", KEY_W'(want.rec.node_b),
                                  KEY_W'(m_axis_tdata[63:48]));
                if (m_axis_tlast !== want.last)
                    flag_mismatch("out_last", KEY_W'(want.last), KEY_W'(m_axis_tlast));
                if (m_axis_tuser !== want.overflow)
                    flag_mismatch("overflow", KEY_W'(want.overflow), KEY_W'(m_axis_tuser));
            end
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_capacity();
        test_random();
        test_backpressure();
        wait_drained();
        repeat (END_SETTLE) @(posedge i_clk);
        $display("Sorted %0d batches from %0d records (%0d with dropped records), %0d words checked,",
                 batches_closed, records_accepted, overflow_batches, words_checked);
        $display("with ties, full and overfull batches, source gaps and sink stalls and hold-off.");
        if (err_count == 0 && pending_sorted.size() == 0) begin
            $display("** quicksort_record_sorter: PASSED **");
        end else begin
            $display("** quicksort_record_sorter: FAILED **");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("** quicksort_record_sorter: FAILED **");
        $finish;
    end

endmodule

/* quicksort_record_sorter.f */
rtl/core/qrs_pkg.sv
rtl/core/quicksort_record_sorter.sv
tb/sv/tb_quicksort_record_sorter.sv
